/* rtl/sorted_priority_queue_defines.svh */
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF

// Concurrent check sampled on the rising clock, held off during reset.
`define SPQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also applies while reset is asserted.
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SPQ_ASSERT(label, clk, rst, prop, msg)
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* rtl/spq_pkg.sv */
// Types and constants for the sorted priority queue.
package spq_pkg;

  // Number of entries the queue holds.
  localparam int CAPACITY = 16;
  // Width of the occupancy count (holds 0 .. CAPACITY).
  localparam int OCC_W = $clog2(CAPACITY + 1);

  localparam int KEY_W = 32;
  localparam int PAY_W = 64;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [KEY_W-1:0]  key;
    logic        [PAY_W-1:0]  payload;
  } item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [KEY_W-1:0]  out_key;
    logic        [PAY_W-1:0]  out_payload;
    logic        [OCC_W-1:0]  occupancy;
  } result_t;

endpackage

/* rtl/sorted_priority_queue.sv */
// Sorted priority queue: register-row list with parallel insert and remove.
//
// Input channel (in_valid / in_stall / in_item) carries one command per
// transfer: enqueue of a signed key with a 64-bit payload, or dequeue of
// the head (smallest key). The output channel (out_valid / out_stall /
// out_result) returns exactly one result per command: status, the removed
// key and payload (zero unless a dequeue succeeded) and the occupancy.
// Every entry sits in its own register; each slot compares its key with the
// incoming one in parallel and shifts from its neighbor. The result is
// registered, so out_valid rises in the cycle after the input transfer,
// and one command is taken every cycle while results drain.
// An enqueue with a key equal to the head's lands just behind the head.
// Enqueue on a full queue drops the entry (status full); dequeue on an
// empty queue reports status empty. Neither changes the contents.
// Reset (rst, synchronous) empties the queue and clears out_valid; entry
// contents are not cleared since only held entries are ever read.
// When out_stall holds a waiting result, in_stall rises and no new command
// is taken until the result transfers.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  spq_pkg::item_t  in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output spq_pkg::result_t out_result
);

  logic signed [spq_pkg::KEY_W-1:0] keys      [spq_pkg::CAPACITY];
  logic        [spq_pkg::PAY_W-1:0] pays      [spq_pkg::CAPACITY];
  logic signed [spq_pkg::KEY_W-1:0] keys_next [spq_pkg::CAPACITY];
  logic        [spq_pkg::PAY_W-1:0] pays_next [spq_pkg::CAPACITY];
  logic        [spq_pkg::OCC_W-1:0] count;
  logic        [spq_pkg::OCC_W-1:0] count_next;
  spq_pkg::result_t                 result_next;

  logic [spq_pkg::CAPACITY-1:0] held;
  logic [spq_pkg::CAPACITY-1:0] after;
  logic                         lt_head;
  logic                         is_full;
  logic                         is_empty;
  logic                         accept;

  // Input is held off only while a result waits on a stalled receiver
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_full  = (count == spq_pkg::OCC_W'(spq_pkg::CAPACITY));
  assign is_empty = (count == '0);

  // Per-slot compare: a slot is at or past the insert point when the new
  // key goes in front of the head, the slot is unused, or (behind the
  // head) its key is not smaller. The list is sorted, so this is monotone.
  always_comb begin
    lt_head = is_empty || (in_item.key < keys[0]);
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      held[i] = (spq_pkg::OCC_W'(i) < count);
    end
    after[0] = lt_head;
    for (int i = 1; i < spq_pkg::CAPACITY; i++) begin
      after[i] = lt_head || !held[i] || (keys[i] >= in_item.key);
    end
  end

  // Next contents of the row and the result for this command
  always_comb begin
    keys_next   = keys;
    pays_next   = pays;
    count_next  = count;
    result_next = '0;
    case (in_item.cmd)
      spq_pkg::CMD_ENQ: begin
        if (is_full) begin
          result_next.status = spq_pkg::ST_FULL;
        end else begin
          result_next.status = spq_pkg::ST_OK;
          count_next = count + 1'b1;
          // head slot: new entry or shifted nothing in
          if (after[0]) begin
            keys_next[0] = in_item.key;
            pays_next[0] = in_item.payload;
          end
          for (int i = 1; i < spq_pkg::CAPACITY; i++) begin
            if (after[i] && !after[i-1]) begin
              keys_next[i] = in_item.key;
              pays_next[i] = in_item.payload;
            end else if (after[i]) begin
              keys_next[i] = keys[i-1];
              pays_next[i] = pays[i-1];
            end
          end
        end
      end
      spq_pkg::CMD_DEQ: begin
        if (is_empty) begin
          result_next.status = spq_pkg::ST_EMPTY;
        end else begin
          result_next.status      = spq_pkg::ST_OK;
          result_next.out_key     = keys[0];
          result_next.out_payload = pays[0];
          count_next = count - 1'b1;
          for (int i = 0; i < spq_pkg::CAPACITY - 1; i++) begin
            keys_next[i] = keys[i+1];
            pays_next[i] = pays[i+1];
          end
        end
      end
      default: begin
        result_next.status = spq_pkg::ST_OK;
      end
    endcase
    result_next.occupancy = count_next;
  end

  // Entry row: payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      keys <= keys_next;
      pays <= pays_next;
    end
  end

  // Occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_result <= result_next;
    end
  end

  // Checks
  `SPQ_ASSERT(a_count_bound, clk, rst, count <= spq_pkg::OCC_W'(spq_pkg::CAPACITY), "count over capacity")
  `SPQ_ASSERT(a_enq_grows, clk, rst, accept && in_item.cmd == spq_pkg::CMD_ENQ && !is_full |=> count == $past(count) + 1'b1, "enqueue did not grow count")
  `SPQ_ASSERT(a_deq_shrinks, clk, rst, accept && in_item.cmd == spq_pkg::CMD_DEQ && !is_empty |=> count == $past(count) - 1'b1 && out_result.out_key == $past(keys[0]), "dequeue mismatch")
  `SPQ_ASSERT(a_full_occ, clk, rst, out_valid && out_result.status == spq_pkg::ST_FULL |-> out_result.occupancy == spq_pkg::OCC_W'(spq_pkg::CAPACITY), "full status with short occupancy")
  `SPQ_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> count == '0 && !out_valid, "reset did not empty queue")

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the sorted priority queue: directed and random commands.
`timescale 1ns / 1ps

module tb;

  localparam int HOLD_CYCLES = 64;
  localparam int IDLE_PCT = 19;
  localparam int RANDOM_ITEMS = 900;

  // Keeps its own sorted copy of the queue and the results it should produce
  class queue_scoreboard;
    logic signed [spq_pkg::KEY_W-1:0] held_keys [spq_pkg::CAPACITY];
    logic [spq_pkg::PAY_W-1:0] held_pays [spq_pkg::CAPACITY];
    int count;
    spq_pkg::result_t awaited[$];
    int errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // Apply one accepted command and queue the result it must produce
    function void note_command(spq_pkg::item_t it);
      spq_pkg::result_t exp;
      logic signed [spq_pkg::KEY_W-1:0] k;
      int slot;
      exp = '0;
      exp.status = spq_pkg::ST_OK;
      k = it.key;
      if (it.cmd == spq_pkg::CMD_ENQ) begin
        if (count >= spq_pkg::CAPACITY) begin
          exp.status = spq_pkg::ST_FULL;
        end else begin
          // head only on a strictly smaller key; ties go just behind the head
          if (count == 0 || k < held_keys[0]) begin
            slot = 0;
          end else begin
            slot = count;
            for (int i = 1; i < count; i++) begin
              if (held_keys[i] >= k) begin
                slot = i;
                break;
              end
            end
          end
          for (int j = count; j > slot; j--) begin
            held_keys[j] = held_keys[j-1];
            held_pays[j] = held_pays[j-1];
          end
          held_keys[slot] = k;
          held_pays[slot] = it.payload;
          count++;
        end
      end else begin
        if (count == 0) begin
          exp.status = spq_pkg::ST_EMPTY;
        end else begin
          exp.out_key = held_keys[0];
          exp.out_payload = held_pays[0];
          for (int j = 0; j < count - 1; j++) begin
            held_keys[j] = held_keys[j+1];
            held_pays[j] = held_pays[j+1];
          end
          count--;
        end
      end
      exp.occupancy = spq_pkg::OCC_W'(count);
      awaited.push_back(exp);
    endfunction

    // Compare one transferred result with the oldest expectation
    function void check_result(spq_pkg::result_t got);
      spq_pkg::result_t exp;
      if (awaited.size() == 0) begin
        $error("unexpected result: status %0d key %0d payload %h occupancy %0d",
               got.status, got.out_key, got.out_payload, got.occupancy);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.out_key !== exp.out_key) begin
        $error("out_key: expected %0d, actual %0d", exp.out_key, got.out_key);
        errors++;
      end
      if (got.out_payload !== exp.out_payload) begin
        $error("out_payload: expected %h, actual %h", exp.out_payload, got.out_payload);
        errors++;
      end
      if (got.occupancy !== exp.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", exp.occupancy, got.occupancy);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  spq_pkg::item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  spq_pkg::result_t out_result;

  // Shared pacing controls, written by the sender only
  logic calm = 1'b0;
  int hold_ticket = 0;

  queue_scoreboard board;

  sorted_priority_queue u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_result(out_result);
    end
  end

  // Receiver back-pressure: random stalls plus long hold-offs on request
  initial begin
    int hold_seen;
    hold_seen = 0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  function automatic spq_pkg::item_t enq_item(logic signed [spq_pkg::KEY_W-1:0] k,
                                              logic [spq_pkg::PAY_W-1:0] p);
    spq_pkg::item_t it;
    it.cmd = spq_pkg::CMD_ENQ;
    it.key = k;
    it.payload = p;
    return it;
  endfunction

  // Dequeue with junk in the ignored fields
  function automatic spq_pkg::item_t deq_item();
    spq_pkg::item_t it;
    it.cmd = spq_pkg::CMD_DEQ;
    it.key = $urandom;
    it.payload = {$urandom, $urandom};
    return it;
  endfunction

  // Mix of near-tie keys, extremes and full-range keys
  function automatic logic signed [spq_pkg::KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      return $signed($urandom_range(0, 8)) - 4;
    end else if (sel == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [spq_pkg::PAY_W-1:0] pick_payload();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one command and hold it until the transfer
  task automatic send(spq_pkg::item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    board.note_command(it);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stop offering until every expected result has transferred
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int mode;
    int run_len;
    int enq_pct;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty dequeue, tie placement, key and payload extremes
    send(deq_item());
    send(enq_item(32'sd5, '1));
    send(enq_item(32'sd5, 64'd1));
    send(enq_item(32'sd5, 64'd2));
    send(enq_item(32'sd4, '0));
    send(enq_item(32'sh8000_0000, 64'h8000_0000_0000_0000));
    send(enq_item(32'sh7fff_ffff, 64'h0123_4567_89ab_cdef));
    send(enq_item(32'sd0, 64'hfedc_ba98_7654_3210));
    send(enq_item(-32'sd1, 64'h5555_5555_5555_5555));
    send(enq_item(32'sh7fff_ffff, 64'haaaa_aaaa_aaaa_aaaa));
    send(enq_item(32'sh8000_0000, 64'd3));
    repeat (12) send(deq_item());
    drain();

    // Random: phases that fill, drain or mix, so both full and empty occur
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      run_len = $urandom_range(10, 40);
      enq_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      repeat (run_len) begin
        calm <= (sent >= 400 && sent < 550);
        if (sent == 250 || sent == 700) begin
          hold_ticket <= hold_ticket + 1;
        end
        if (sent == 600) begin
          drain();
        end
        if ($urandom_range(0, 99) < enq_pct) begin
          send(enq_item(pick_key(), pick_payload()));
        end else begin
          send(deq_item());
        end
        sent++;
      end
    end

    // Wind down
    calm <= 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
